FILE: rtl/slt_pkg.sv
// Package for the sorted list table: sizes, command and status codes,
// sequencer states and the structs passed between the top level and the sequencer.
// No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 2;

	// command codes (codes 5 to 7 are no-ops)
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PRESENT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_KTH     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RUN,
		S_INS_LAST,
		S_REM_RUN,
		S_PRE_RUN,
		S_KTH_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        position;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic                    found;
		logic signed [VAL_W-1:0] entry_value;
		logic [CNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic                    en;
		logic [ADDR_W-1:0]       addr;
		logic signed [VAL_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage

FILE: rtl/sorted_list_table.sv
// Top level of the sorted list table: stream ports, output register,
// sequencer and entry RAM. Depends on slt_pkg, slt_seq and slt_ram.
//
//  port group   dir  fields (lowest bit up)
//  s_*          in   tuser: command[2:0]; tdata: value[31:0], position[38:32]
//  m_*          out  tdata: status[1:0], found[2], entry_value[34:3], entry_count[41:35]
//
// One command at a time. Insert, remove and present walk the entries one at a time,
// kth reads a single entry, and clear and the rest read none; each result is then
// handed to the output register: the walk is set by the single read port of the entry RAM.
// The next command is taken while a result waits in the output register.
// Reset empties the list at once (fill count cleared); entries are not cleared.
`timescale 1ns / 1ps

module sorted_list_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero pad
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status, found, entry_value, entry_count, zero pad
);

	import slt_pkg::*;

	localparam int OUT_W = STAT_W + 1 + VAL_W + CNT_W;

	req_t    req;
	rsp_t    rsp;
	rsp_t    out_q;
	logic    m_tvalid_q;
	logic    idle;
	logic    rsp_valid;
	logic    rsp_take;
	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	logic [VAL_W-1:0] ram_rd_data;

	// unpack the input beat
	assign req.command  = s_tuser;
	assign req.value    = $signed(s_tdata[VAL_W-1:0]);
	assign req.position = s_tdata[VAL_W+CNT_W-1:VAL_W];

	assign s_tready = idle;
	assign rsp_take = !m_tvalid_q || m_tready;

	slt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (s_tvalid && idle),
		.req         (req),
		.idle        (idle),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.rsp_take    (rsp_take),
		.ram_wr      (ram_wr),
		.ram_rd      (ram_rd),
		.ram_rd_data (ram_rd_data)
	);

	slt_ram #(
		.DEPTH  (CAPACITY),
		.WIDTH  (VAL_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (ram_rd.en),
		.rd_addr (ram_rd.addr),
		.rd_data (ram_rd_data)
	);

	// output valid: load on a finished result, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp_take) begin
			m_tvalid_q <= rsp_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (rsp_take && rsp_valid) begin
			out_q <= rsp;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(48 - OUT_W){1'b0}}, out_q.entry_count, out_q.entry_value,
		out_q.found, out_q.status};

endmodule

FILE: rtl/slt_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module slt_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/slt_seq.sv
// Command sequencer for the sorted list table: walks the entry RAM one entry per cycle
// to insert, remove and search, reads a single entry to index; holds the fill count.
// Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  slt_pkg::req_t   req,
	output logic            idle,
	output logic            rsp_valid,
	output slt_pkg::rsp_t   rsp,
	input  logic            rsp_take,
	output slt_pkg::ram_wr_t ram_wr,
	output slt_pkg::ram_rd_t ram_rd,
	input  logic [slt_pkg::VAL_W-1:0] ram_rd_data
);

	import slt_pkg::*;

	localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(CAPACITY);
	localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic              found_q, found_d;
	req_t              req_q, req_d;
	rsp_t              res_q, res_d;

	logic signed [VAL_W-1:0] rdata;
	logic [ADDR_W-1:0]       last_addr;
	logic                    at_last;
	logic                    hit;
	logic [CNT_W-1:0]        fill_inc;
	logic [CNT_W-1:0]        fill_dec;

	assign rdata     = $signed(ram_rd_data);
	assign last_addr = ADDR_W'(fill_q - CNT_ONE);
	assign at_last   = (ptr_q == last_addr);
	assign hit       = found_q || (rdata == req_q.value);
	assign fill_inc  = fill_q + CNT_ONE;
	assign fill_dec  = fill_q - CNT_ONE;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			found_q <= found_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		req_q <= req_d;
		res_q <= res_d;
	end

	// next state, RAM accesses and result
	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		ptr_d   = ptr_q;
		found_d = found_q;
		req_d   = req_q;
		res_d   = res_q;
		ram_wr  = '0;
		ram_rd  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d             = req;
					found_d           = 1'b0;
					res_d.status      = ST_OK;
					res_d.found       = 1'b0;
					res_d.entry_value = '0;
					res_d.entry_count = fill_q;
					state_d           = S_DONE;
					case (req.command)
						CMD_INSERT: begin
							if (fill_q == CNT_CAP) begin
								res_d.status = ST_FULL;
							end else if (fill_q == '0) begin
								ram_wr.en         = 1'b1;
								ram_wr.addr       = '0;
								ram_wr.data       = req.value;
								fill_d            = CNT_ONE;
								res_d.entry_count = CNT_ONE;
							end else begin
								// walk down from the top entry
								ram_rd.en   = 1'b1;
								ram_rd.addr = last_addr;
								ptr_d       = last_addr;
								state_d     = S_INS_RUN;
							end
						end
						CMD_REMOVE: begin
							if (fill_q == '0) begin
								res_d.status = ST_NOT_FOUND;
							end else begin
								ram_rd.en = 1'b1;
								ptr_d     = '0;
								state_d   = S_REM_RUN;
							end
						end
						CMD_PRESENT: begin
							if (fill_q != '0) begin
								ram_rd.en = 1'b1;
								ptr_d     = '0;
								state_d   = S_PRE_RUN;
							end
						end
						CMD_KTH: begin
							if (req.position == '0 || req.position > fill_q) begin
								res_d.status = ST_BAD_INDEX;
							end else begin
								ram_rd.en   = 1'b1;
								ram_rd.addr = ADDR_W'(req.position - CNT_ONE);
								state_d     = S_KTH_WAIT;
							end
						end
						CMD_CLEAR: begin
							fill_d            = '0;
							res_d.entry_count = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_RUN: begin
				// shift larger or equal entries up by one; drop the value above the first smaller one
				ram_wr.en   = 1'b1;
				ram_wr.addr = ptr_q + ADDR_ONE;
				if (rdata < req_q.value) begin
					ram_wr.data       = req_q.value;
					fill_d            = fill_inc;
					res_d.entry_count = fill_inc;
					state_d           = S_DONE;
				end else begin
					ram_wr.data = rdata;
					if (ptr_q == '0) begin
						state_d = S_INS_LAST;
					end else begin
						ram_rd.en   = 1'b1;
						ram_rd.addr = ptr_q - ADDR_ONE;
						ptr_d       = ptr_q - ADDR_ONE;
					end
				end
			end
			S_INS_LAST: begin
				// value is the new smallest entry
				ram_wr.en         = 1'b1;
				ram_wr.addr       = '0;
				ram_wr.data       = req_q.value;
				fill_d            = fill_inc;
				res_d.entry_count = fill_inc;
				state_d           = S_DONE;
			end
			S_REM_RUN: begin
				// after the first match, move each entry down by one
				found_d = hit;
				if (found_q) begin
					ram_wr.en   = 1'b1;
					ram_wr.addr = ptr_q - ADDR_ONE;
					ram_wr.data = rdata;
				end
				if (at_last) begin
					if (hit) begin
						fill_d            = fill_dec;
						res_d.entry_count = fill_dec;
					end else begin
						res_d.status = ST_NOT_FOUND;
					end
					state_d = S_DONE;
				end else begin
					ram_rd.en   = 1'b1;
					ram_rd.addr = ptr_q + ADDR_ONE;
					ptr_d       = ptr_q + ADDR_ONE;
				end
			end
			S_PRE_RUN: begin
				// stop at the first match or the top entry
				if (rdata == req_q.value) begin
					res_d.found = 1'b1;
					state_d     = S_DONE;
				end else if (at_last) begin
					state_d = S_DONE;
				end else begin
					ram_rd.en   = 1'b1;
					ram_rd.addr = ptr_q + ADDR_ONE;
					ptr_d       = ptr_q + ADDR_ONE;
				end
			end
			S_KTH_WAIT: begin
				res_d.entry_value = rdata;
				state_d           = S_DONE;
			end
			S_DONE: begin
				if (rsp_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign rsp       = res_q;

endmodule
